### rtl/rth_pkg.sv
// Shared types and constants for the RGB to HSL pixel converter.
`timescale 1ns / 1ps

package rth_pkg;

    localparam int ChanW   = 8;
    localparam int NumW    = 16;
    localparam int DivSteps = 8;
    localparam int DegW    = 10;
    localparam int ScaleW  = 10;

    // floor(deg * 255 / 360) is floor(floor(deg * 17 / 8) / 3), and the
    // division by three is a multiply by 683 and a shift by 11.
    localparam int unsigned HueRecip = 683;
    localparam int          HueShift = 11;

    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    // Per-pixel information that rides beside the two dividers.
    typedef struct packed {
        logic              grey;
        logic              neg;
        sector_t           sector;
        logic [ChanW-1:0]  lig;
    } sideband_t;

    typedef struct packed {
        logic [ChanW-1:0] hue;
        logic [ChanW-1:0] sat;
        logic [ChanW-1:0] lig;
    } result_t;

endpackage

### rtl/rth_if.sv
// Valid/ready channel interfaces for RGB input pixels and HSL output pixels.
`timescale 1ns / 1ps

interface rth_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsl_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

### rtl/rth_div_step.sv
// One registered step of a restoring divider that settles one quotient bit.
`timescale 1ns / 1ps

module rth_div_step #(
    parameter int SHIFT = 0
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rth_pkg::NumW-1:0]  num,
    input  logic [rth_pkg::ChanW-1:0] den,
    input  logic [rth_pkg::ChanW-1:0] quo,
    output logic [rth_pkg::NumW-1:0]  num_out,
    output logic [rth_pkg::ChanW-1:0] den_out,
    output logic [rth_pkg::ChanW-1:0] quo_out
);
    import rth_pkg::*;

    logic [NumW-1:0]  shifted;
    logic             fits;
    logic [NumW-1:0]  num_next;
    logic [ChanW-1:0] quo_next;
    logic [NumW-1:0]  num_reg;
    logic [ChanW-1:0] den_reg;
    logic [ChanW-1:0] quo_reg;

    always_comb
    begin
        shifted  = NumW'(den) << SHIFT;
        fits     = (num >= shifted);
        num_next = fits ? (num - shifted) : num;
        quo_next = quo | (ChanW'(fits) << SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den;
            quo_reg <= quo_next;
        end
    end

    assign num_out = num_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

### rtl/rgb_to_hsl_pixel_top.sv
// Top level of the pipelined RGB to HSL pixel converter.
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel per clock into 8-bit hue, saturation and
// lightness. Between its input and output beats a pixel passes, in order,
// the stage that finds the extremes, the stage that builds the numerators,
// the two restoring dividers (one quotient bit per stage), the stage that
// applies the hue sector, the stage that scales the degrees to a byte, and
// the output register. A single skid register behind the output register
// lets the input keep taking beats while a result waits; when both are full
// the whole pipeline holds and rgb.ready falls. Hue for grey pixels and
// saturation for grey pixels are zero.
module rgb_to_hsl_pixel_top (
    input  logic clk,
    input  logic rst_n,
    rth_rgb_if.sink   rgb,
    rth_hsl_if.source hsl
);
    import rth_pkg::*;

    logic en;

    // Stage 1: extremes, difference, sum, sector.
    logic                    v1_reg;
    logic [ChanW-1:0]        mx, mn;
    sector_t                 sector_next;
    logic signed [ChanW:0]   x_next;
    logic [ChanW-1:0]        d1_reg;
    logic [ChanW:0]          sum1_reg;
    logic signed [ChanW:0]   x1_reg;
    sector_t                 sector1_reg;

    always_comb
    begin
        mx = rgb.red;
        mn = rgb.red;
        if (rgb.green > mx) mx = rgb.green;
        if (rgb.blue > mx)  mx = rgb.blue;
        if (rgb.green < mn) mn = rgb.green;
        if (rgb.blue < mn)  mn = rgb.blue;
        priority if (mx == rgb.red)
        begin
            sector_next = SECTOR_RED;
            x_next = $signed({1'b0, rgb.green}) - $signed({1'b0, rgb.blue});
        end
        else if (mx == rgb.green)
        begin
            sector_next = SECTOR_GREEN;
            x_next = $signed({1'b0, rgb.blue}) - $signed({1'b0, rgb.red});
        end
        else
        begin
            sector_next = SECTOR_BLUE;
            x_next = $signed({1'b0, rgb.red}) - $signed({1'b0, rgb.green});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg      <= mx - mn;
            sum1_reg    <= {1'b0, mx} + {1'b0, mn};
            x1_reg      <= x_next;
            sector1_reg <= sector_next;
        end
    end

    // Stage 2: numerators and divisors for hue and saturation.
    logic [ChanW-1:0] x_abs;
    logic [ChanW:0]   sden_wide;
    sideband_t        sb_next;

    logic [NumW-1:0]  hnum_s [0:DivSteps];
    logic [ChanW-1:0] hden_s [0:DivSteps];
    logic [ChanW-1:0] hquo_s [0:DivSteps];
    logic [NumW-1:0]  snum_s [0:DivSteps];
    logic [ChanW-1:0] sden_s [0:DivSteps];
    logic [ChanW-1:0] squo_s [0:DivSteps];
    sideband_t        sb_reg [0:DivSteps];
    logic [DivSteps:0] vdiv_reg;

    logic [NumW-1:0]  hnum2_reg, snum2_reg;
    logic [ChanW-1:0] hden2_reg, sden2_reg;

    always_comb
    begin
        x_abs = x1_reg[ChanW] ? ChanW'(-x1_reg) : x1_reg[ChanW-1:0];
        sden_wide = (sum1_reg >= (ChanW+1)'(255)) ? ((ChanW+1)'(510) - sum1_reg) : sum1_reg;
        sb_next.grey   = (d1_reg == '0);
        sb_next.neg    = x1_reg[ChanW];
        sb_next.sector = sector1_reg;
        sb_next.lig    = sum1_reg[ChanW:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hnum2_reg <= (NumW'(x_abs) << 6) - (NumW'(x_abs) << 2);
            hden2_reg <= d1_reg;
            snum2_reg <= (NumW'(d1_reg) << 8) - NumW'(d1_reg);
            sden2_reg <= sden_wide[ChanW-1:0];
            sb_reg[0] <= sb_next;
        end
    end

    assign hnum_s[0] = hnum2_reg;
    assign hden_s[0] = hden2_reg;
    assign hquo_s[0] = '0;
    assign snum_s[0] = snum2_reg;
    assign sden_s[0] = sden2_reg;
    assign squo_s[0] = '0;

    // Stages 3 to 10: both dividers, most significant quotient bit first.
    for (genvar k = 0; k < DivSteps; k++)
    begin : g_div
        rth_div_step #(.SHIFT(DivSteps - 1 - k)) u_hue_step (
            .clk     (clk),
            .en      (en),
            .num     (hnum_s[k]),
            .den     (hden_s[k]),
            .quo     (hquo_s[k]),
            .num_out (hnum_s[k+1]),
            .den_out (hden_s[k+1]),
            .quo_out (hquo_s[k+1])
        );

        rth_div_step #(.SHIFT(DivSteps - 1 - k)) u_sat_step (
            .clk     (clk),
            .en      (en),
            .num     (snum_s[k]),
            .den     (sden_s[k]),
            .quo     (squo_s[k]),
            .num_out (snum_s[k+1]),
            .den_out (sden_s[k+1]),
            .quo_out (squo_s[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k+1] <= sb_reg[k];
            end
        end
    end

    // Stage 11: floor of the signed ratio, sector offset, wrap, times 17/8.
    sideband_t               sb_last;
    logic [DegW-1:0]         hq_ext;
    logic signed [DegW-1:0]  mag;
    logic signed [DegW-1:0]  offset;
    logic signed [DegW-1:0]  deg_s;
    logic [DegW-2:0]         deg_u;
    logic [DegW+3:0]         deg17;
    logic                    v11_reg;
    logic [ScaleW-1:0]       y11_reg;
    logic [ChanW-1:0]        sat11_reg, lig11_reg;

    always_comb
    begin
        sb_last = sb_reg[DivSteps];
        // A negative ratio with a remainder rounds one further down.
        hq_ext = DegW'(hquo_s[DivSteps]) + DegW'(hnum_s[DivSteps] != '0);
        mag = sb_last.neg ? -$signed(hq_ext) : $signed(DegW'(hquo_s[DivSteps]));
        unique case (sb_last.sector)
            SECTOR_RED:   offset = DegW'(0);
            SECTOR_GREEN: offset = DegW'(120);
            SECTOR_BLUE:  offset = DegW'(240);
            default:      offset = DegW'(0);
        endcase
        deg_s = mag + offset;
        if (deg_s < 0)
        begin
            deg_s = deg_s + DegW'(360);
        end
        deg_u = sb_last.grey ? '0 : deg_s[DegW-2:0];
        deg17 = ({5'b0, deg_u} << 4) + {5'b0, deg_u};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y11_reg   <= deg17[DegW+2:3];
            sat11_reg <= sb_last.grey ? '0 : squo_s[DivSteps];
            lig11_reg <= sb_last.lig;
        end
    end

    // Stage 12: divide by three through the reciprocal.
    logic [2*ScaleW-1:0] hue_prod;
    logic                v12_reg;
    result_t             res12_reg;

    assign hue_prod = y11_reg * ScaleW'(HueRecip);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res12_reg.hue <= hue_prod[HueShift+ChanW-1:HueShift];
            res12_reg.sat <= sat11_reg;
            res12_reg.lig <= lig11_reg;
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            vdiv_reg <= '0;
            v11_reg  <= 1'b0;
            v12_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= rgb.valid;
            vdiv_reg <= {vdiv_reg[DivSteps-1:0], v1_reg};
            v11_reg  <= vdiv_reg[DivSteps];
            v12_reg  <= v11_reg;
        end
    end

    // Output register with a skid register behind it.
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    out_busy;

    assign en       = !skid_valid_reg;
    assign out_busy = out_valid_reg && !hsl.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_busy)
        begin
            if (en && v12_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= en && v12_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_busy)
        begin
            if (en && v12_reg)
            begin
                skid_reg <= res12_reg;
            end
        end
        else if (skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (en && v12_reg)
        begin
            out_reg <= res12_reg;
        end
    end

    assign rgb.ready      = en;
    assign hsl.valid      = out_valid_reg;
    assign hsl.hue        = out_reg.hue;
    assign hsl.saturation = out_reg.sat;
    assign hsl.lightness  = out_reg.lig;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb.valid && rgb.ready) |=> v1_reg)
        else $error("accepted pixel did not enter the first stage");

    a_blocked_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_busy && !skid_valid_reg && v12_reg) |=> skid_valid_reg)
        else $error("finished pixel was not caught by the skid register");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.hue != 8'hFF))
        else $error("hue out of range");

endmodule
